@@ rtl/bsu_pkg.sv @@
// Shared types, constants and the UTF-8 encoder for the BOM sniffing transcoder.
package bsu_pkg;

   typedef enum logic [1:0] {
      MODE_UTF8 = 2'd0,
      MODE_LE   = 2'd1,
      MODE_BE   = 2'd2
   } mode_type;

   localparam logic [1:0] HDR_DONE = 2'd3;

   localparam logic [7:0] BOM_LE_0   = 8'hFF;
   localparam logic [7:0] BOM_LE_1   = 8'hFE;
   localparam logic [7:0] BOM_BE_0   = 8'hFE;
   localparam logic [7:0] BOM_BE_1   = 8'hFF;
   localparam logic [7:0] BOM_UTF8_0 = 8'hEF;
   localparam logic [7:0] BOM_UTF8_1 = 8'hBB;
   localparam logic [7:0] BOM_UTF8_2 = 8'hBF;

   localparam logic [20:0] SUPP_BASE = 21'h10000;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } utf8_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic [1:0]      encoding;
   } group_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
         r.last_idx = 2'd0;
      end else if (cp < 21'h800) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.last_idx = 2'd1;
      end else if (cp < 21'h10000) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.last_idx = 2'd2;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.last_idx = 2'd3;
      end
      return r;
   endfunction

endpackage

@@ rtl/bsu_front.sv @@
// Front end: accepts bytes, sniffs the mark, pairs units and builds output byte groups.
module bsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               req_end_of_input,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   input  logic               queue_full,
   output logic               push_valid,
   output bsu_pkg::group_type push_data
);
   import bsu_pkg::*;

   logic            sniff_bom_ff;
   logic [1:0]      hdr_count_ff, hdr_count_in;
   logic [2:0][7:0] hdr_bytes_ff, hdr_bytes_in;
   mode_type        mode_ff, mode_in;
   logic [7:0]      half_byte_ff, half_byte_in;
   logic            half_valid_ff, half_valid_in;
   logic [10:0]     high_sur_ff, high_sur_in;
   logic            sur_pend_ff, sur_pend_in;

   logic            accept;
   logic            emit;
   group_type       grp;
   logic [15:0]     unit;
   logic [20:0]     cp;
   utf8_type        enc;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      hdr_count_in  = hdr_count_ff;
      hdr_bytes_in  = hdr_bytes_ff;
      mode_in       = mode_ff;
      half_byte_in  = half_byte_ff;
      half_valid_in = half_valid_ff;
      high_sur_in   = high_sur_ff;
      sur_pend_in   = sur_pend_ff;
      emit          = 1'b0;
      grp           = '0;
      grp.encoding  = mode_ff;
      unit          = '0;
      cp            = '0;
      enc           = '0;
      if (req_end_of_input) begin
         if (hdr_count_ff != HDR_DONE) begin
            grp.bytes[0] = hdr_bytes_ff[0];
            grp.bytes[1] = hdr_bytes_ff[1];
            grp.bytes[2] = hdr_bytes_ff[2];
            grp.last_idx = hdr_count_ff - 2'd1;
            emit         = (hdr_count_ff != 2'd0);
         end else if (half_valid_ff || sur_pend_ff) begin
            emit = 1'b1;
         end
         hdr_count_in  = '0;
         hdr_bytes_in  = '0;
         mode_in       = MODE_UTF8;
         half_byte_in  = '0;
         half_valid_in = 1'b0;
         high_sur_in   = '0;
         sur_pend_in   = 1'b0;
      end else if (hdr_count_ff != HDR_DONE) begin
         if (hdr_count_ff == 2'd0 && !sniff_bom_ff) begin
            hdr_count_in = HDR_DONE;
            mode_in      = MODE_UTF8;
            grp.bytes[0] = req_in_byte;
            grp.encoding = MODE_UTF8;
            emit         = 1'b1;
         end else begin
            case (hdr_count_ff)
               2'd0: begin
                  hdr_bytes_in[0] = req_in_byte;
                  hdr_count_in    = 2'd1;
               end
               2'd1: begin
                  hdr_bytes_in[1] = req_in_byte;
                  hdr_count_in    = 2'd2;
                  if (hdr_bytes_ff[0] == BOM_LE_0 && req_in_byte == BOM_LE_1) begin
                     mode_in      = MODE_LE;
                     hdr_count_in = HDR_DONE;
                  end else if (hdr_bytes_ff[0] == BOM_BE_0 && req_in_byte == BOM_BE_1) begin
                     mode_in      = MODE_BE;
                     hdr_count_in = HDR_DONE;
                  end
               end
               default: begin
                  hdr_bytes_in[2] = req_in_byte;
                  hdr_count_in    = HDR_DONE;
                  mode_in         = MODE_UTF8;
                  grp.encoding    = MODE_UTF8;
                  grp.bytes[0]    = hdr_bytes_ff[0];
                  grp.bytes[1]    = hdr_bytes_ff[1];
                  grp.bytes[2]    = req_in_byte;
                  grp.last_idx    = 2'd2;
                  emit = !(hdr_bytes_ff[0] == BOM_UTF8_0 && hdr_bytes_ff[1] == BOM_UTF8_1
                           && req_in_byte == BOM_UTF8_2);
               end
            endcase
         end
      end else if (mode_ff == MODE_LE || mode_ff == MODE_BE) begin
         if (!half_valid_ff) begin
            half_byte_in  = req_in_byte;
            half_valid_in = 1'b1;
         end else begin
            half_valid_in = 1'b0;
            half_byte_in  = '0;
            unit = (mode_ff == MODE_LE) ? {req_in_byte, half_byte_ff}
                                        : {half_byte_ff, req_in_byte};
            if (sur_pend_ff) begin
               sur_pend_in = 1'b0;
               high_sur_in = '0;
               emit        = 1'b1;
               if (unit[15:10] == 6'b110111 && !high_sur_ff[10]) begin
                  cp           = {1'b0, high_sur_ff[9:0], unit[9:0]} + SUPP_BASE;
                  enc          = utf8_encode(cp);
                  grp.bytes    = enc.bytes;
                  grp.last_idx = enc.last_idx;
               end
            end else if (unit[15:11] == 5'b11011) begin
               high_sur_in = unit[10:0];
               sur_pend_in = 1'b1;
            end else begin
               cp           = {5'd0, unit};
               enc          = utf8_encode(cp);
               grp.bytes    = enc.bytes;
               grp.last_idx = enc.last_idx;
               emit         = 1'b1;
            end
         end
      end else begin
         grp.bytes[0] = req_in_byte;
         emit         = 1'b1;
      end
   end

   assign push_valid = accept && emit;
   assign push_data  = grp;

   always_ff @(posedge clock) begin
      if (reset) begin
         sniff_bom_ff  <= 1'b1;
         hdr_count_ff  <= '0;
         hdr_bytes_ff  <= '0;
         mode_ff       <= MODE_UTF8;
         half_byte_ff  <= '0;
         half_valid_ff <= 1'b0;
         high_sur_ff   <= '0;
         sur_pend_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            sniff_bom_ff <= csr_write_data;
         end
         if (accept) begin
            hdr_count_ff  <= hdr_count_in;
            hdr_bytes_ff  <= hdr_bytes_in;
            mode_ff       <= mode_in;
            half_byte_ff  <= half_byte_in;
            half_valid_ff <= half_valid_in;
            high_sur_ff   <= high_sur_in;
            sur_pend_ff   <= sur_pend_in;
         end
      end
   end

endmodule

@@ rtl/bsu_queue.sv @@
// Two-entry queue of output byte groups between front and back.
module bsu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  bsu_pkg::group_type push_data,
   output logic               full,
   output logic               pop_valid,
   input  logic               pop,
   output bsu_pkg::group_type pop_data
);
   import bsu_pkg::*;

   group_type  entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_valid && !(pop && pop_valid)) begin
         count_in = count_ff + 2'd1;
      end else if (!push_valid && pop && pop_valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && pop_valid) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

endmodule

@@ rtl/bsu_back.sv @@
// Back end: unloads byte groups and sends them out one item per cycle while rsp_ready is high.
module bsu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  bsu_pkg::group_type pop_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_run,
   output logic [1:0]         rsp_encoding
);
   import bsu_pkg::*;

   group_type  work_ff;
   logic       valid_ff;
   logic [1:0] idx_ff;
   logic       done;

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = work_ff.bytes[idx_ff];
   assign rsp_last_of_run = (idx_ff == work_ff.last_idx);
   assign rsp_encoding    = work_ff.encoding;

   assign done = !valid_ff || (rsp_ready && rsp_last_of_run);
   assign pop  = done && pop_valid;

   always_ff @(posedge clock) begin
      if (pop) begin
         work_ff <= pop_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (done) begin
         valid_ff <= pop_valid;
         idx_ff   <= '0;
      end else if (rsp_ready) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

`ifndef SYNTHESIS
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff <= work_ff.last_idx)
      else $error("byte index past end of group");

   a_run_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=> rsp_valid)
      else $error("group ended before its last item");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=> idx_ff == $past(idx_ff) + 2'd1)
      else $error("byte index did not advance");
`endif

endmodule

@@ rtl/bom_sniffing_utf16_to_utf8.sv @@
// Top level of the BOM sniffing UTF-16 to UTF-8 transcoder.
// Throughput: one input item per cycle while the queue is not full, one result item
// per cycle while rsp_ready is high; a code point goes out as up to four bytes.
// A two-group queue lets the front take items while the back is busy.
// Reset (synchronous): clears stream state and the queue; sniff_bom returns to 1.
module bom_sniffing_utf16_to_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic [1:0] rsp_encoding,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import bsu_pkg::*;

   logic      push_valid;
   group_type push_data;
   logic      queue_full;
   logic      pop_valid;
   logic      pop;
   group_type pop_data;

   bsu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   bsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   bsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_encoding    (rsp_encoding)
   );

endmodule

@@ tb/transcode_check.sv @@
// Result checker for the BOM sniffing transcoder: watches both channels, predicts the UTF-8 bytes.
module transcode_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last_of_run,
   input  logic [1:0] rsp_encoding,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   output int         mismatch_count,
   output int         bytes_outstanding,
   output int         bytes_checked
);
   import bsu_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic [1:0] enc;
   } utf8_byte_type;

   utf8_byte_type utf8_expected[$];
   utf8_byte_type want;

   logic       sniff_on = 1'b1;
   logic [1:0] hdr_count;
   logic [7:0] hdr_bytes [0:2];
   mode_type   src_mode;
   logic [7:0] half_byte;
   logic       half_valid;
   logic [10:0] hi_sur;
   logic       sur_pending;

   int errors = 0;
   int checked = 0;

   assign mismatch_count    = errors;
   assign bytes_outstanding = utf8_expected.size();
   assign bytes_checked     = checked;

   function automatic void clear_stream();
      hdr_count   = 2'd0;
      hdr_bytes   = '{default: 8'h00};
      src_mode    = MODE_UTF8;
      half_byte   = 8'h00;
      half_valid  = 1'b0;
      hi_sur      = 11'd0;
      sur_pending = 1'b0;
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      utf8_expected.push_back('{data: b, last: 1'b0, enc: src_mode});
   endfunction

   function automatic void encode_cp(input logic [20:0] cp);
      if (cp < 21'h80) begin
         put_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         put_byte(8'hC0 | 8'(cp >> 6));
         put_byte(8'h80 | 8'(cp & 21'h3F));
      end else if (cp < 21'h10000) begin
         put_byte(8'hE0 | 8'(cp >> 12));
         put_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
         put_byte(8'h80 | 8'(cp & 21'h3F));
      end else begin
         put_byte(8'hF0 | 8'((cp >> 18) & 21'h07));
         put_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
         put_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
         put_byte(8'h80 | 8'(cp & 21'h3F));
      end
   endfunction

   function automatic void take_code_unit(input logic [15:0] u);
      logic [15:0] lo;
      logic [10:0] hi;
      if (sur_pending) begin
         lo = u - 16'hDC00;
         hi = hi_sur;
         sur_pending = 1'b0;
         hi_sur = 11'd0;
         if (lo > 16'h3FF || hi > 11'h3FF)
            put_byte(8'h00);
         else
            encode_cp((21'(hi) << 10) + 21'(lo) + 21'h10000);
      end else if (u >= 16'hD800 && u <= 16'hDFFF) begin
         hi_sur = u[10:0];
         sur_pending = 1'b1;
      end else if (u == 16'h0000) begin
         put_byte(8'h00);
      end else begin
         encode_cp(21'(u));
      end
   endfunction

   function automatic void take_header_byte(input logic [7:0] b);
      if (hdr_count == 2'd0 && !sniff_on) begin
         hdr_count = HDR_DONE;
         src_mode = MODE_UTF8;
         put_byte(b);
         return;
      end
      hdr_bytes[hdr_count] = b;
      hdr_count = hdr_count + 2'd1;
      if (hdr_count == 2'd2) begin
         if (hdr_bytes[0] == BOM_LE_0 && hdr_bytes[1] == BOM_LE_1) begin
            src_mode = MODE_LE;
            hdr_count = HDR_DONE;
         end else if (hdr_bytes[0] == BOM_BE_0 && hdr_bytes[1] == BOM_BE_1) begin
            src_mode = MODE_BE;
            hdr_count = HDR_DONE;
         end
      end else if (hdr_count == 2'd3) begin
         src_mode = MODE_UTF8;
         if (!(hdr_bytes[0] == BOM_UTF8_0 && hdr_bytes[1] == BOM_UTF8_1 &&
               hdr_bytes[2] == BOM_UTF8_2)) begin
            put_byte(hdr_bytes[0]);
            put_byte(hdr_bytes[1]);
            put_byte(hdr_bytes[2]);
         end
      end
   endfunction

   function automatic void transcode_item(input logic [7:0] b, input logic eoi);
      int first;
      utf8_byte_type tail;
      first = utf8_expected.size();
      if (eoi) begin
         if (hdr_count != HDR_DONE) begin
            for (int i = 0; i < int'(hdr_count); i++)
               put_byte(hdr_bytes[i]);
         end else if (half_valid || sur_pending) begin
            put_byte(8'h00);
         end
      end else if (hdr_count != HDR_DONE) begin
         take_header_byte(b);
      end else if (src_mode == MODE_LE || src_mode == MODE_BE) begin
         if (!half_valid) begin
            half_byte = b;
            half_valid = 1'b1;
         end else begin
            half_valid = 1'b0;
            if (src_mode == MODE_LE)
               take_code_unit({b, half_byte});
            else
               take_code_unit({half_byte, b});
            half_byte = 8'h00;
         end
      end else begin
         put_byte(b);
      end
      if (utf8_expected.size() > first) begin
         tail = utf8_expected.pop_back();
         tail.last = 1'b1;
         utf8_expected.push_back(tail);
      end
      if (eoi)
         clear_stream();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         sniff_on = 1'b1;
         clear_stream();
         utf8_expected.delete();
      end else begin
         if (req_valid && req_ready)
            transcode_item(req_in_byte, req_end_of_input);
         if (rsp_valid && rsp_ready) begin
            if (utf8_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got byte %02h last %0b enc %0d",
                        $time, rsp_out_byte, rsp_last_of_run, rsp_encoding);
            end else begin
               want = utf8_expected.pop_front();
               checked++;
               if (rsp_out_byte !== want.data) begin
                  errors++;
                  $display("%0t: out_byte expected %02h got %02h",
                           $time, want.data, rsp_out_byte);
               end
               if (rsp_last_of_run !== want.last) begin
                  errors++;
                  $display("%0t: last_of_run expected %0b got %0b",
                           $time, want.last, rsp_last_of_run);
               end
               if (rsp_encoding !== want.enc) begin
                  errors++;
                  $display("%0t: encoding expected %0d got %0d",
                           $time, want.enc, rsp_encoding);
               end
            end
         end
         if (csr_write_enable)
            sniff_on = csr_write_data;
      end
   end

endmodule

@@ tb/bom_sniffing_utf16_to_utf8_test.sv @@
// Top of the transcoder testbench: clock, reset, stimulus, receiver pacing and verdict.
module bom_sniffing_utf16_to_utf8_test;
   import bsu_pkg::*;

   localparam logic [8:0] END_ITEM = 9'h100;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_end_of_input;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic [1:0] rsp_encoding;
   logic       csr_write_enable;
   logic       csr_write_data;

   int mismatch_count;
   int bytes_outstanding;
   int bytes_checked;

   int items_sent = 0;
   int streams_sent = 0;
   int eager_left = 0;
   int hold_off_asked = 0;

   logic [8:0] directed_items [0:24] = '{
      9'h0FF, 9'h0FE, 9'h000, 9'h000, 9'h0FF, 9'h0DB, 9'h0FF, 9'h0DF,
      9'h000, 9'h0DC, 9'h041, 9'h000, 9'h07F, END_ITEM,
      9'h0FE, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0D8, 9'h000, END_ITEM,
      9'h0EF, 9'h0BB, 9'h0BF, END_ITEM
   };

   bom_sniffing_utf16_to_utf8 dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_encoding     (rsp_encoding),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   transcode_check results (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_input  (req_end_of_input),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_encoding      (rsp_encoding),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding),
      .bytes_checked     (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("timeout with %0d result bytes outstanding", bytes_outstanding);
      $display("FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (eager_left > 0 || r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input logic [7:0] b, input logic eoi);
      int gap;
      gap = pick_gap();
      if (eager_left > 0)
         eager_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_input <= eoi;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_unit(input logic [15:0] u, input mode_type m);
      if (m == MODE_LE) begin
         send_item(u[7:0], 1'b0);
         send_item(u[15:8], 1'b0);
      end else begin
         send_item(u[15:8], 1'b0);
         send_item(u[7:0], 1'b0);
      end
   endtask

   task automatic send_code_point(input mode_type m);
      int r;
      logic [15:0] u;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         send_unit(16'($urandom_range(16'h0000, 16'h007F)), m);
      end else if (r < 30) begin
         send_unit(16'($urandom_range(16'h0080, 16'h07FF)), m);
      end else if (r < 50) begin
         u = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                  : 16'($urandom_range(16'hE000, 16'hFFFF));
         send_unit(u, m);
      end else if (r < 75) begin
         send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), m);
         send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), m);
      end else if (r < 85) begin
         send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), m);
         send_unit(16'($urandom), m);
      end else if (r < 95) begin
         send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), m);
         send_unit(16'($urandom), m);
      end else begin
         send_unit(16'($urandom), m);
      end
   endtask

   function automatic logic [7:0] header_byte();
      case ($urandom_range(0, 9))
         0, 1: return BOM_LE_0;
         2, 3: return BOM_LE_1;
         4: return BOM_UTF8_0;
         5: return BOM_UTF8_1;
         6: return BOM_UTF8_2;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_bom_stream();
      int r;
      mode_type m;
      r = $urandom_range(0, 99);
      streams_sent++;
      if ($urandom_range(0, 9) == 0)
         eager_left = 15;
      if (r < 70) begin
         m = (r < 35) ? MODE_LE : MODE_BE;
         if (m == MODE_LE) begin
            send_item(BOM_LE_0, 1'b0);
            send_item(BOM_LE_1, 1'b0);
         end else begin
            send_item(BOM_BE_0, 1'b0);
            send_item(BOM_BE_1, 1'b0);
         end
         repeat ($urandom_range(1, 6)) send_code_point(m);
         if ($urandom_range(0, 99) < 15)
            send_item(8'($urandom), 1'b0);
      end else if (r < 80) begin
         send_item(BOM_UTF8_0, 1'b0);
         send_item(BOM_UTF8_1, 1'b0);
         send_item(BOM_UTF8_2, 1'b0);
         repeat ($urandom_range(0, 5)) send_item(8'($urandom), 1'b0);
      end else if (r < 92) begin
         repeat (3) send_item(header_byte(), 1'b0);
         repeat ($urandom_range(0, 5)) send_item(8'($urandom), 1'b0);
      end else begin
         repeat ($urandom_range(0, 2)) send_item(header_byte(), 1'b0);
      end
      send_item(8'($urandom), 1'b1);
   endtask

   task automatic send_plain_stream();
      streams_sent++;
      repeat ($urandom_range(0, 8)) send_item(8'($urandom), 1'b0);
      send_item(8'($urandom), 1'b1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (bytes_outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_sniff(input logic on);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= on;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : receiver
      int hold_n;
      int served;
      int r;
      hold_n = 0;
      served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (served != hold_off_asked) begin
            served = hold_off_asked;
            rsp_ready <= 1'b0;
            hold_n = 199;
         end else if (hold_n > 0) begin
            hold_n--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_ready <= 1'b1;
               hold_n = $urandom_range(0, 3);
            end else if (r < 85) begin
               rsp_ready <= 1'b0;
               hold_n = $urandom_range(0, 2);
            end else if (r < 95) begin
               rsp_ready <= 1'b1;
               hold_n = $urandom_range(30, 60);
            end else begin
               rsp_ready <= 1'b0;
               hold_n = $urandom_range(15, 40);
            end
         end
      end
   end

   initial begin : stimulus
      bit pressure_done;
      pressure_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      req_end_of_input = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_items[i])
         send_item(directed_items[i][7:0], directed_items[i][8]);
      streams_sent += 3;

      write_sniff(1'b0);
      while (items_sent < 85)
         send_plain_stream();

      write_sniff(1'b1);
      while (items_sent < 360) begin
         if (!pressure_done && items_sent >= 180) begin
            pressure_done = 1'b1;
            hold_off_asked++;
            eager_left = 40;
         end
         send_bom_stream();
      end
      settle();

      $display("Sent %0d items in %0d streams, sniffing on and off, UTF-16LE/BE and UTF-8.",
               items_sent, streams_sent);
      $display("Checked %0d result bytes, including a long receiver hold-off.", bytes_checked);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
